FILE: hdl/smx_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// smx_pkg
// Shared types, widths and tables for the softmax/argmax classifier head.
// ---------------------------------------------------------------------------
package smx_pkg;

	localparam int DEF_MAX_CLASSES     = 8;
	localparam int DEF_LOGIT_FRAC_BITS = 8;

	localparam int LOGIT_W   = 16;
	localparam int PROB_W    = 17;
	localparam int CLASS_W   = 3;
	localparam int LOG2E_Q16 = 94548;
	localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_EXP_RD,
		ST_EXP_GO,
		ST_EXP_WAIT,
		ST_DIV_RD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} smx_state_t;

	// 2^(-k/16) in Q16, entry 16 is 0.5
	function automatic logic [PROB_W-1:0] pow2_neg(input logic [4:0] k);
		logic [PROB_W-1:0] v;
		case (k)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd62757;
			5'd2:    v = 17'd60097;
			5'd3:    v = 17'd57549;
			5'd4:    v = 17'd55109;
			5'd5:    v = 17'd52773;
			5'd6:    v = 17'd50535;
			5'd7:    v = 17'd48393;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd44376;
			5'd10:   v = 17'd42495;
			5'd11:   v = 17'd40693;
			5'd12:   v = 17'd38968;
			5'd13:   v = 17'd37316;
			5'd14:   v = 17'd35734;
			5'd15:   v = 17'd34219;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/smx_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// smx_in_if
// Logit channel: valid/ready with one signed logit and the last flag.
// ---------------------------------------------------------------------------
interface smx_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] logit;
	logic        last;

	modport source (output valid, output logit, output last, input ready);
	modport sink (input valid, input logit, input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/smx_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// smx_out_if
// Probability channel: valid/ready with one class probability per transaction.
// ---------------------------------------------------------------------------
interface smx_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  class_index;
	logic [16:0] probability;
	logic        is_last;
	logic [2:0]  predicted_class;
	logic [16:0] predicted_score;
	logic        overflow;

	modport source (output valid, output class_index, output probability, output is_last,
		output predicted_class, output predicted_score, output overflow, input ready);
	modport sink (input valid, input class_index, input probability, input is_last,
		input predicted_class, input predicted_score, input overflow, output ready);
endinterface
`default_nettype wire

FILE: hdl/smx_exp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// smx_exp
// Three-stage exp(-t) unit: log2(e) scaling, table interpolation, shift.
// ---------------------------------------------------------------------------
module smx_exp #(
	parameter int LOGIT_FRAC_BITS = smx_pkg::DEF_LOGIT_FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [smx_pkg::LOGIT_W-1:0]  t,
	output logic                              done,
	output logic [smx_pkg::PROB_W-1:0]        e
);
	import smx_pkg::*;

	localparam int Y_W = LOGIT_W + 17;
	localparam int N_W = Y_W - LOGIT_FRAC_BITS - 16;

	logic [Y_W-1:0]    y_s1;
	logic              v1_s1, v2_s2, v3_s3;
	logic [15:0]       f;
	logic [N_W-1:0]    n;
	logic [4:0]        k;
	logic [PROB_W-1:0] a, b, v;
	logic [11:0]       diff;
	logic [23:0]       prod;
	logic [PROB_W-1:0] v_s2;
	logic              sat_s2;
	logic [4:0]        n_s2;
	logic [PROB_W:0]   rnd;
	logic [PROB_W-1:0] e_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			v1_s1 <= start;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		y_s1 <= Y_W'(t) * Y_W'(LOG2E_Q16);
	end

	always_comb begin
		f    = y_s1[LOGIT_FRAC_BITS +: 16];
		n    = y_s1[Y_W-1 -: N_W];
		k    = {1'b0, f[15:12]};
		a    = pow2_neg(k);
		b    = pow2_neg(k + 5'd1);
		diff = 12'(a - b);
		prod = 24'(diff) * 24'(f[11:0]);
		v    = a - PROB_W'((prod + 24'd2048) >> 12);
	end

	always_ff @(posedge clk) begin
		v_s2   <= v;
		sat_s2 <= (n >= N_W'(17));
		n_s2   <= n[4:0];
	end

	// round half up before the shift
	always_comb begin
		if (n_s2 == 5'd0) begin
			rnd = {1'b0, v_s2};
		end else begin
			rnd = ({1'b0, v_s2} + ((PROB_W+1)'(1) << (n_s2 - 5'd1))) >> n_s2;
		end
	end

	always_ff @(posedge clk) begin
		e_s3 <= sat_s2 ? '0 : rnd[PROB_W-1:0];
	end

	assign done = v3_s3;
	assign e    = e_s3;

endmodule
`default_nettype wire

FILE: hdl/smx_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// smx_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module smx_div #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 20
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);
	import smx_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q, num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[NUM_W-2:0], fits};
			num_q <= num_q << 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_W)) else $error("divider count out of range");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
`endif

endmodule
`default_nettype wire

FILE: hdl/softmax_argmax_head.sv
`default_nettype none
// ---------------------------------------------------------------------------
// softmax_argmax_head
// Classifier head: stores logits, then emits softmax probabilities and argmax.
// ---------------------------------------------------------------------------
// Usage: logits enter on the sample channel one per transaction; ready stays
// high while the vector is collected. A transaction with last set closes
// the vector and the block then drops ready until every probability of the
// vector has been taken on the result channel, in class order. The final
// result carries is_last, the argmax class and its probability (ties to the
// lowest class). Logits beyond MAX_CLASSES are discarded and set overflow.
// Order: first an exp pass over the stored classes (memory read plus the
// 3-stage exp unit per class), then a divide pass (memory read plus the
// serial divider per class), each quotient emitted before the next class.
// The divider sets the rate.
// The result register holds its transaction until ready is seen; a stall
// just halts the sequencer. Reset empties the vector, clears the maximum,
// sum, argmax and overflow, and leaves the block ready for a new vector.
// ---------------------------------------------------------------------------
module softmax_argmax_head #(
	parameter int MAX_CLASSES     = smx_pkg::DEF_MAX_CLASSES,
	parameter int LOGIT_FRAC_BITS = smx_pkg::DEF_LOGIT_FRAC_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	smx_in_if.sink   sample,
	smx_out_if.source result
);
	import smx_pkg::*;

	localparam int IDX_W = $clog2(MAX_CLASSES);
	localparam int CNT_W = $clog2(MAX_CLASSES + 1);
	localparam int SUM_W = PROB_W + IDX_W;
	localparam int NUM_W = 34;

	smx_state_t state_q, state_d;

	logic signed [LOGIT_W-1:0] logit_mem [MAX_CLASSES];
	logic [PROB_W-1:0]         exp_mem [MAX_CLASSES];
	logic signed [LOGIT_W-1:0] logit_rd_q;
	logic [PROB_W-1:0]         exp_rd_q;

	logic signed [LOGIT_W-1:0] max_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [IDX_W-1:0]          idx_q;
	logic [SUM_W-1:0]          sum_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic [PROB_W-1:0]         best_prob_q;
	logic                      drop_q;

	logic                      in_ready, exp_start, div_start, out_valid;
	logic                      in_take, out_take, idx_is_last;
	logic                      exp_done, div_done;
	logic [PROB_W-1:0]         e_val;
	logic [LOGIT_W-1:0]        t_val;
	logic [NUM_W-1:0]          num_val, quo_val;
	logic [PROB_W-1:0]         p_val;
	logic                      p_best;

	logic [CLASS_W-1:0]        class_q, pred_class_q;
	logic [PROB_W-1:0]         prob_q, pred_score_q;
	logic                      is_last_q, ovf_q;

	assign in_take     = sample.valid && in_ready;
	assign out_take    = out_valid && result.ready;
	assign idx_is_last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT:  if (in_take && sample.last) state_d = ST_EXP_RD;
			ST_EXP_RD:   state_d = ST_EXP_GO;
			ST_EXP_GO:   state_d = ST_EXP_WAIT;
			ST_EXP_WAIT: if (exp_done) state_d = idx_is_last ? ST_DIV_RD : ST_EXP_RD;
			ST_DIV_RD:   state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_d = ST_EMIT;
			ST_EMIT:     if (out_take) state_d = idx_is_last ? ST_COLLECT : ST_DIV_RD;
			default:     state_d = ST_COLLECT;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		exp_start = 1'b0;
		div_start = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_COLLECT: in_ready  = 1'b1;
			ST_EXP_GO:  exp_start = 1'b1;
			ST_DIV_GO:  div_start = 1'b1;
			ST_EMIT:    out_valid = 1'b1;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			max_q       <= {1'b1, {(LOGIT_W-1){1'b0}}};
			cnt_q       <= '0;
			idx_q       <= '0;
			sum_q       <= '0;
			best_idx_q  <= '0;
			best_prob_q <= '0;
			drop_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				if (cnt_q < CNT_W'(MAX_CLASSES)) begin
					cnt_q <= cnt_q + 1'b1;
					if ($signed(sample.logit) > max_q) max_q <= $signed(sample.logit);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (state_q == ST_EXP_WAIT && exp_done) begin
				sum_q <= sum_q + SUM_W'(e_val);
				idx_q <= idx_is_last ? '0 : idx_q + 1'b1;
			end
			if (state_q == ST_DIV_WAIT && div_done && p_best) begin
				best_idx_q  <= idx_q;
				best_prob_q <= p_val;
			end
			if (out_take) begin
				if (idx_is_last) begin
					max_q       <= {1'b1, {(LOGIT_W-1){1'b0}}};
					cnt_q       <= '0;
					idx_q       <= '0;
					sum_q       <= '0;
					best_idx_q  <= '0;
					best_prob_q <= '0;
					drop_q      <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// vector storage, read data registered
	always_ff @(posedge clk) begin
		if (in_take && cnt_q < CNT_W'(MAX_CLASSES)) begin
			logit_mem[cnt_q[IDX_W-1:0]] <= $signed(sample.logit);
		end
		if (state_q == ST_EXP_WAIT && exp_done) begin
			exp_mem[idx_q] <= e_val;
		end
		logit_rd_q <= logit_mem[idx_q];
		exp_rd_q   <= exp_mem[idx_q];
	end

	assign t_val = LOGIT_W'(max_q - logit_rd_q);

	smx_exp #(
		.LOGIT_FRAC_BITS(LOGIT_FRAC_BITS)
	) u_exp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (exp_start),
		.t     (t_val),
		.done  (exp_done),
		.e     (e_val)
	);

	assign num_val = (NUM_W'(exp_rd_q) << 16) + NUM_W'(sum_q >> 1);

	smx_div #(
		.NUM_W(NUM_W),
		.DEN_W(SUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_val),
		.den   (sum_q),
		.done  (div_done),
		.quo   (quo_val)
	);

	assign p_val  = (quo_val > NUM_W'(ONE_Q16)) ? ONE_Q16 : quo_val[PROB_W-1:0];
	assign p_best = (idx_q == '0) || (p_val > best_prob_q);

	// result register, loaded when a quotient is ready
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_WAIT && div_done) begin
			class_q   <= CLASS_W'(idx_q);
			prob_q    <= p_val;
			is_last_q <= idx_is_last;
			ovf_q     <= drop_q;
			if (idx_is_last) begin
				pred_class_q <= p_best ? CLASS_W'(idx_q) : CLASS_W'(best_idx_q);
				pred_score_q <= p_best ? p_val : best_prob_q;
			end else begin
				pred_class_q <= '0;
				pred_score_q <= '0;
			end
		end
	end

	assign sample.ready           = in_ready;
	assign result.valid           = out_valid;
	assign result.class_index     = class_q;
	assign result.probability     = prob_q;
	assign result.is_last         = is_last_q;
	assign result.predicted_class = pred_class_q;
	assign result.predicted_score = pred_score_q;
	assign result.overflow        = ovf_q;

`ifndef NO_ASSERTIONS
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CLASSES)) else $error("entry count above capacity");
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COLLECT) |-> (cnt_q != '0)) else $error("empty vector in compute");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && result.is_last) |=> (cnt_q == '0 && state_q == ST_COLLECT))
		else $error("run state not cleared after final result");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COLLECT) |-> (CNT_W'(idx_q) < cnt_q)) else $error("index past count");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the softmax/argmax classifier head. Logit vectors
// are driven with random gaps. A scoreboard computes the fixed-point softmax
// and argmax of each closed vector and checks every probability in order.
// ---------------------------------------------------------------------------

typedef struct packed {
	logic [2:0]  class_index;
	logic [16:0] probability;
	logic        is_last;
	logic [2:0]  predicted_class;
	logic [16:0] predicted_score;
	logic        overflow;
} prob_rec_t;

class softmax_scoreboard;
	localparam int CAP = smx_pkg::DEF_MAX_CLASSES;
	localparam int FRAC = smx_pkg::DEF_LOGIT_FRAC_BITS;

	int unsigned exp2_tab[16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
		48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};

	logic signed [15:0] logits[CAP];
	logic signed [15:0] vec_max;
	int unsigned        n_stored;
	bit                 dropped;
	prob_rec_t          expected_probs[$];
	int                 mismatches;
	int                 checked;
	int                 vectors;
	int                 overflow_vectors;

	function new();
		mismatches = 0;
		checked = 0;
		vectors = 0;
		overflow_vectors = 0;
		clear_vector();
	endfunction

	function void clear_vector();
		vec_max = -16'sd32768;
		n_stored = 0;
		dropped = 0;
	endfunction

	// exp(-t) in Q1.16 via 2^-(t*log2e), table plus linear interpolation
	function int unsigned exp_neg(int unsigned t);
		longint unsigned y;
		longint unsigned n;
		int unsigned f, k, r, a, b, v;
		y = longint'(t) * smx_pkg::LOG2E_Q16;
		n = y >> (FRAC + 16);
		f = int'((y >> FRAC) & 64'hFFFF);
		k = f >> 12;
		r = f & 12'hFFF;
		a = exp2_tab[k];
		b = (k < 15) ? exp2_tab[k+1] : 32768;
		v = a - (((a - b) * r + 2048) >> 12);
		if (n >= 17)
			return 0;
		if (n == 0)
			return v;
		return (v + (1 << (n - 1))) >> n;
	endfunction

	function void note_logit(logic [15:0] logit, logic last);
		int unsigned e[CAP];
		int unsigned sum, p, best_p, best_i;
		longint unsigned q;
		prob_rec_t rec;
		if (n_stored < CAP) begin
			logits[n_stored] = logit;
			if ($signed(logit) > vec_max)
				vec_max = logit;
			n_stored++;
		end else begin
			dropped = 1;
		end
		if (!last)
			return;
		sum = 0;
		for (int i = 0; i < n_stored; i++) begin
			e[i] = exp_neg(int'(vec_max) - int'(logits[i]));
			sum += e[i];
		end
		best_p = 0;
		best_i = 0;
		for (int i = 0; i < n_stored; i++) begin
			q = (longint'(e[i]) * 65536 + (sum >> 1)) / sum;
			p = (q > 65536) ? 65536 : int'(q);
			if (i == 0 || p > best_p) begin
				best_p = p;
				best_i = i;
			end
			rec.class_index = i[2:0];
			rec.probability = p[16:0];
			rec.is_last = (i == n_stored - 1);
			rec.predicted_class = rec.is_last ? best_i[2:0] : 3'd0;
			rec.predicted_score = rec.is_last ? best_p[16:0] : 17'd0;
			rec.overflow = dropped;
			expected_probs.insert(expected_probs.size(), rec);
		end
		vectors++;
		if (dropped)
			overflow_vectors++;
		clear_vector();
	endfunction

	function void check_prob(prob_rec_t got);
		prob_rec_t want;
		if (expected_probs.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("error: unexpected result class %0d prob %0d",
					got.class_index, got.probability);
			return;
		end
		want = expected_probs.pop_front();
		checked++;
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"error: result %0d exp cls %0d p %0d last %0d pc %0d ps %0d ov %0d",
					" / got cls %0d p %0d last %0d pc %0d ps %0d ov %0d"}, checked,
					want.class_index, want.probability, want.is_last, want.predicted_class,
					want.predicted_score, want.overflow, got.class_index, got.probability,
					got.is_last, got.predicted_class, got.predicted_score, got.overflow);
		end
	endfunction

	function int pending();
		return expected_probs.size();
	endfunction
endclass

module tb_top;
	logic clk;
	logic arst_n;
	bit   quiet;
	bit   hold_req;
	int   items_sent;

	softmax_scoreboard sb;

	smx_in_if  sample();
	smx_out_if result();

	softmax_argmax_head DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12.0 * 1500000);
		$display("softmax_argmax_head regression: fail");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		prob_rec_t got;
		if (arst_n && sb != null && result.valid && result.ready) begin
			got.class_index = result.class_index;
			got.probability = result.probability;
			got.is_last = result.is_last;
			got.predicted_class = result.predicted_class;
			got.predicted_score = result.predicted_score;
			got.overflow = result.overflow;
			sb.check_prob(got);
		end
	end

	task automatic send_logit(logic [15:0] logit, logic last);
		sample.valid <= 1'b1;
		sample.logit <= logit;
		sample.last <= last;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
		sb.note_logit(logit, last);
		items_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// mode 0: full range, 1: clustered near a base, 2: all equal
	task automatic send_vector(int len, int mode);
		logic [15:0] base;
		logic [15:0] v;
		base = $urandom;
		for (int i = 0; i < len; i++) begin
			case (mode)
				0:       v = $urandom;
				1:       v = base + 16'($signed($urandom_range(0, 2047)) - 1024);
				default: v = base;
			endcase
			send_logit(v, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int len, mode;
		bit hold_done, drain_done;
		sb = new();
		quiet = 0;
		hold_req = 0;
		hold_done = 0;
		drain_done = 0;
		items_sent = 0;
		sample.valid <= 1'b0;
		sample.logit <= '0;
		sample.last <= 1'b0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single entry, extremes, ties, underflow to zero, overflow
		send_logit(16'h8000, 1'b1);
		send_logit(16'h7FFF, 1'b1);
		send_logit(16'h8000, 1'b0);
		send_logit(16'h7FFF, 1'b1);
		send_logit(16'h0000, 1'b0);
		send_logit(16'h0010, 1'b0);
		send_logit(16'hF000, 1'b1);
		send_vector(8, 2);
		for (int i = 0; i < 10; i++)
			send_logit(16'(i * 256), i == 9);

		// random vectors; mostly in capacity, some overflow
		while (items_sent < 520) begin
			if (items_sent > 440)
				quiet = 1;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
			mode = $urandom_range(0, 9);
			mode = (mode < 4) ? 0 : (mode < 9) ? 1 : 2;
			if (items_sent > 150 && !hold_done) begin
				hold_req = 1;
				hold_done = 1;
			end
			if (items_sent > 300 && !drain_done) begin
				drain_done = 1;
				sample.valid <= 1'b0;
				wait_drained();
				@(posedge clk);
			end
			send_vector(len, mode);
		end
		sample.valid <= 1'b0;

		wait_drained();
		repeat (500) @(posedge clk);
		$display("covered %0d logits in %0d vectors (%0d with dropped logits), %0d probabilities",
			items_sent, sb.vectors, sb.overflow_vectors, sb.checked);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("softmax_argmax_head regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
			$display("softmax_argmax_head regression: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
